// ===== sv/tbkt_pkg.sv =====
// Package for the terminal byte to key tap translator.
// Tap and tap list types, keysym and character constants, and the single byte key map.
// No dependencies.
`default_nettype none

package tbkt_pkg;

  localparam int unsigned MaxTaps = 4;

  localparam logic [15:0] KS_BACKSPACE = 16'hff08;
  localparam logic [15:0] KS_TAB       = 16'hff09;
  localparam logic [15:0] KS_RETURN    = 16'hff0d;
  localparam logic [15:0] KS_ESCAPE    = 16'hff1b;
  localparam logic [15:0] KS_HOME      = 16'hff50;
  localparam logic [15:0] KS_LEFT      = 16'hff51;
  localparam logic [15:0] KS_UP        = 16'hff52;
  localparam logic [15:0] KS_RIGHT     = 16'hff53;
  localparam logic [15:0] KS_DOWN      = 16'hff54;
  localparam logic [15:0] KS_END       = 16'hff57;
  localparam logic [15:0] KS_DELETE    = 16'hffff;

  localparam logic [7:0] CH_ESC      = 8'h1b;
  localparam logic [7:0] CH_DEL      = 8'h7f;
  localparam logic [7:0] CH_LBRACKET = 8'h5b;
  localparam logic [7:0] CH_THREE    = 8'h33;
  localparam logic [7:0] CH_TILDE    = 8'h7e;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_UP       = 8'h41;
  localparam logic [7:0] CH_DOWN     = 8'h42;
  localparam logic [7:0] CH_RIGHT    = 8'h43;
  localparam logic [7:0] CH_LEFT     = 8'h44;
  localparam logic [7:0] CH_END      = 8'h46;
  localparam logic [7:0] CH_HOME     = 8'h48;

  // Pending escape prefix
  typedef enum logic [3:0] {
    P_NONE  = 4'b0001,
    P_ESC   = 4'b0010,
    P_BRKT  = 4'b0100,
    P_THREE = 4'b1000
  } prefix_e;

  typedef struct packed {
    logic [15:0] sym;
    logic        shift;
    logic        ctrl;
  } tap_t;

  typedef struct packed {
    logic        vld;
    tap_t        tap;
  } key_t;

  typedef struct packed {
    tap_t [MaxTaps-1:0] taps;
    logic [2:0]         count;
  } tap_list_t;

  // Number of taps a pending prefix flushes to
  function automatic logic [1:0] flush_len(input prefix_e pre);
    logic [1:0] len;
    case (pre)
      P_ESC:   len = 2'd1;
      P_BRKT:  len = 2'd2;
      P_THREE: len = 2'd3;
      default: len = 2'd0;
    endcase
    return len;
  endfunction

  function automatic tap_t flush_tap(input logic [1:0] pos);
    tap_t t;
    case (pos)
      2'd0:    t = '{sym: KS_ESCAPE, shift: 1'b0, ctrl: 1'b0};
      2'd1:    t = '{sym: {8'h00, CH_LBRACKET}, shift: 1'b0, ctrl: 1'b0};
      default: t = '{sym: {8'h00, CH_THREE}, shift: 1'b0, ctrl: 1'b0};
    endcase
    return t;
  endfunction

  // Base key of a shifted US layout symbol; zero when not a shifted symbol
  function automatic logic [7:0] shifted_base(input logic [7:0] b);
    logic [7:0] base;
    case (b)
      8'h21:   base = 8'h31;
      8'h40:   base = 8'h32;
      8'h23:   base = 8'h33;
      8'h24:   base = 8'h34;
      8'h25:   base = 8'h35;
      8'h5e:   base = 8'h36;
      8'h26:   base = 8'h37;
      8'h2a:   base = 8'h38;
      8'h28:   base = 8'h39;
      8'h29:   base = 8'h30;
      8'h5f:   base = 8'h2d;
      8'h2b:   base = 8'h3d;
      8'h7b:   base = 8'h5b;
      8'h7d:   base = 8'h5d;
      8'h7c:   base = 8'h5c;
      8'h3a:   base = 8'h3b;
      8'h22:   base = 8'h27;
      8'h7e:   base = 8'h60;
      8'h3c:   base = 8'h2c;
      8'h3e:   base = 8'h2e;
      8'h3f:   base = 8'h2f;
      default: base = 8'h00;
    endcase
    return base;
  endfunction

  function automatic key_t plain_key(input logic [7:0] b);
    key_t       k;
    logic [7:0] base;
    k    = '0;
    base = shifted_base(b);
    if (b == 8'h0a || b == 8'h0d) begin
      k = '{vld: 1'b1, tap: '{sym: KS_RETURN, shift: 1'b0, ctrl: 1'b0}};
    end else if (b == 8'h09) begin
      k = '{vld: 1'b1, tap: '{sym: KS_TAB, shift: 1'b0, ctrl: 1'b0}};
    end else if (b == 8'h08 || b == CH_DEL) begin
      k = '{vld: 1'b1, tap: '{sym: KS_BACKSPACE, shift: 1'b0, ctrl: 1'b0}};
    end else if (b >= 8'h01 && b <= 8'h1a) begin
      k = '{vld: 1'b1, tap: '{sym: {8'h00, b + 8'h60}, shift: 1'b0, ctrl: 1'b1}};
    end else if (b >= 8'h41 && b <= 8'h5a) begin
      k = '{vld: 1'b1, tap: '{sym: {8'h00, b + 8'h20}, shift: 1'b1, ctrl: 1'b0}};
    end else if (base != 8'h00) begin
      k = '{vld: 1'b1, tap: '{sym: {8'h00, base}, shift: 1'b1, ctrl: 1'b0}};
    end else if (b >= CH_SPACE && b <= CH_TILDE) begin
      k = '{vld: 1'b1, tap: '{sym: {8'h00, b}, shift: 1'b0, ctrl: 1'b0}};
    end
    return k;
  endfunction

endpackage

`default_nettype wire

// ===== sv/tbkt_decode.sv =====
// Escape prefix decoder: builds the full tap list for one byte from the pending prefix.
// Purely combinational. Depends on tbkt_pkg.
`default_nettype none

module tbkt_decode (
  input  wire logic [7:0]          data_byte_i,
  input  wire logic                end_of_record_i,
  input  wire tbkt_pkg::prefix_e   prefix_i,
  output tbkt_pkg::prefix_e        prefix_o,
  output tbkt_pkg::tap_list_t      list_o
);

  tbkt_pkg::key_t      plain_c;
  tbkt_pkg::tap_list_t list_c;
  tbkt_pkg::prefix_e   pre_nx_c;
  tbkt_pkg::prefix_e   flush_c;
  tbkt_pkg::tap_t      direct_tap_c;
  logic                direct_vld_c;
  logic                fresh_c;
  logic [1:0]          flen_c;
  logic [1:0]          elen_c;

  assign plain_c = tbkt_pkg::plain_key(data_byte_i);

  always_comb begin
    list_c       = '0;
    pre_nx_c     = tbkt_pkg::P_NONE;
    flush_c      = tbkt_pkg::P_NONE;
    fresh_c      = 1'b0;
    direct_vld_c = 1'b0;
    direct_tap_c = '0;

    case (prefix_i)
      tbkt_pkg::P_ESC: begin
        if (data_byte_i == tbkt_pkg::CH_LBRACKET) begin
          pre_nx_c = tbkt_pkg::P_BRKT;
        end else begin
          flush_c = tbkt_pkg::P_ESC;
          fresh_c = 1'b1;
        end
      end
      tbkt_pkg::P_BRKT: begin
        direct_vld_c = 1'b1;
        case (data_byte_i)
          tbkt_pkg::CH_UP:    direct_tap_c.sym = tbkt_pkg::KS_UP;
          tbkt_pkg::CH_DOWN:  direct_tap_c.sym = tbkt_pkg::KS_DOWN;
          tbkt_pkg::CH_RIGHT: direct_tap_c.sym = tbkt_pkg::KS_RIGHT;
          tbkt_pkg::CH_LEFT:  direct_tap_c.sym = tbkt_pkg::KS_LEFT;
          tbkt_pkg::CH_HOME:  direct_tap_c.sym = tbkt_pkg::KS_HOME;
          tbkt_pkg::CH_END:   direct_tap_c.sym = tbkt_pkg::KS_END;
          default: begin
            direct_vld_c = 1'b0;
            if (data_byte_i == tbkt_pkg::CH_THREE) begin
              pre_nx_c = tbkt_pkg::P_THREE;
            end else begin
              flush_c = tbkt_pkg::P_BRKT;
              fresh_c = 1'b1;
            end
          end
        endcase
      end
      tbkt_pkg::P_THREE: begin
        if (data_byte_i == tbkt_pkg::CH_TILDE) begin
          direct_vld_c     = 1'b1;
          direct_tap_c.sym = tbkt_pkg::KS_DELETE;
        end else begin
          flush_c = tbkt_pkg::P_THREE;
          fresh_c = 1'b1;
        end
      end
      default: fresh_c = 1'b1;
    endcase

    if (direct_vld_c) begin
      list_c.taps[0] = direct_tap_c;
      list_c.count   = 3'd1;
    end

    // broken prefix: Escape then the bytes after it
    flen_c = tbkt_pkg::flush_len(flush_c);
    for (int j = 0; j < 3; j++) begin
      if (2'(j) < flen_c && list_c.count < 3'(tbkt_pkg::MaxTaps)) begin
        list_c.taps[list_c.count[1:0]] = tbkt_pkg::flush_tap(2'(j));
        list_c.count                   = list_c.count + 3'd1;
      end
    end

    if (fresh_c) begin
      if (data_byte_i == tbkt_pkg::CH_ESC) begin
        pre_nx_c = tbkt_pkg::P_ESC;
      end else if (plain_c.vld && list_c.count < 3'(tbkt_pkg::MaxTaps)) begin
        list_c.taps[list_c.count[1:0]] = plain_c.tap;
        list_c.count                   = list_c.count + 3'd1;
      end
    end

    // end of record flushes whatever is still pending
    elen_c = end_of_record_i ? tbkt_pkg::flush_len(pre_nx_c) : 2'd0;
    for (int j = 0; j < 3; j++) begin
      if (2'(j) < elen_c && list_c.count < 3'(tbkt_pkg::MaxTaps)) begin
        list_c.taps[list_c.count[1:0]] = tbkt_pkg::flush_tap(2'(j));
        list_c.count                   = list_c.count + 3'd1;
      end
    end
    if (end_of_record_i) begin
      pre_nx_c = tbkt_pkg::P_NONE;
    end
  end

  assign prefix_o = pre_nx_c;
  assign list_o   = list_c;

endmodule

`default_nettype wire

// ===== sv/tbkt_tap_queue.sv =====
// Result register for one tap list, sent out one tap per transfer.
// Flags the final tap of the list. Depends on tbkt_pkg.
`default_nettype none

module tbkt_tap_queue (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                load_i,
  input  wire tbkt_pkg::tap_list_t list_i,
  output logic                     free_o,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [15:0]              key_symbol_o,
  output logic                     with_shift_o,
  output logic                     with_control_o,
  output logic                     last_of_run_o
);

  tbkt_pkg::tap_t [tbkt_pkg::MaxTaps-1:0] taps_q;
  logic       valid_q, valid_d;
  logic [1:0] idx_q, idx_d;
  logic [1:0] last_q;
  logic       fire;
  logic       at_last;
  tbkt_pkg::tap_t cur;

  assign cur     = taps_q[idx_q];
  assign at_last = (idx_q == last_q);
  assign fire    = valid_q && !out_stall_i;
  assign free_o  = !valid_q || (fire && at_last);

  always_comb begin
    valid_d = valid_q;
    idx_d   = idx_q;
    if (load_i) begin
      valid_d = 1'b1;
      idx_d   = 2'd0;
    end else if (fire) begin
      if (at_last) begin
        valid_d = 1'b0;
      end else begin
        idx_d = idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 2'd0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      taps_q <= list_i.taps;
      last_q <= 2'(list_i.count - 3'd1);
    end
  end

  assign out_valid_o    = valid_q;
  assign key_symbol_o   = cur.sym;
  assign with_shift_o   = cur.shift;
  assign with_control_o = cur.ctrl;
  assign last_of_run_o  = at_last;

endmodule

`default_nettype wire

// ===== sv/terminal_bytes_to_key_taps.sv =====
// Terminal byte to key tap translator, top level. A byte passes the input register and
// the result register before its first tap is valid. One byte per cycle if each gives
// at most one tap and the receiver does not stall; a list of up to four taps leaves one
// per transfer. Reset (asynchronous, active low) empties the input and result registers and
// clears the pending escape prefix. Depends on tbkt_pkg, tbkt_decode and tbkt_tap_queue.
`default_nettype none

module terminal_bytes_to_key_taps (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        end_of_record_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [15:0]      key_symbol_o,
  output logic             with_shift_o,
  output logic             with_control_o,
  output logic             last_of_run_o
);

  logic                in_valid_q, in_valid_d;
  logic [7:0]          byte_q;
  logic                eor_q;
  tbkt_pkg::prefix_e   prefix_q, prefix_d;
  tbkt_pkg::prefix_e   prefix_nx;
  tbkt_pkg::tap_list_t list;
  logic                free;
  logic                move;
  logic                load;
  logic                accept;

  tbkt_decode u_decode (
    .data_byte_i     (byte_q),
    .end_of_record_i (eor_q),
    .prefix_i        (prefix_q),
    .prefix_o        (prefix_nx),
    .list_o          (list)
  );

  assign move   = in_valid_q && ((list.count == 3'd0) || free);
  assign load   = move && (list.count != 3'd0);
  assign in_stall_o = in_valid_q && !move;
  assign accept = in_valid_i && !in_stall_o;

  assign in_valid_d = accept ? 1'b1 : (move ? 1'b0 : in_valid_q);
  assign prefix_d   = move ? prefix_nx : prefix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      prefix_q   <= tbkt_pkg::P_NONE;
    end else begin
      in_valid_q <= in_valid_d;
      prefix_q   <= prefix_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= data_byte_i;
      eor_q  <= end_of_record_i;
    end
  end

  tbkt_tap_queue u_queue (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (load),
    .list_i         (list),
    .free_o         (free),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .key_symbol_o   (key_symbol_o),
    .with_shift_o   (with_shift_o),
    .with_control_o (with_control_o),
    .last_of_run_o  (last_of_run_o)
  );

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// Testbench for terminal_bytes_to_key_taps: drives terminal bytes under random idling,
// predicts the key taps in a scoreboard class and checks every tap transfer in order.
// Depends on tbkt_pkg and the terminal_bytes_to_key_taps RTL.
`timescale 1ns / 100ps

import tbkt_pkg::*;

typedef struct packed {
  logic [15:0] sym;
  logic        shift;
  logic        ctrl;
  logic        last;
} key_tap_t;

class tap_scoreboard;
  key_tap_t due[$];
  key_tap_t run[$];
  prefix_e  pend = P_NONE;
  int       errors = 0;
  int       checked = 0;
  string    shifted_set = "!@#$%^&*()_+{}|:\"~<>?";
  string    base_set = "1234567890-=[]\\;'`,./";

  function void push_key(logic [15:0] sym, logic sh, logic ct);
    run.push_back('{sym, sh, ct, 1'b0});
  endfunction

  function void plain_taps(logic [7:0] b);
    bit hit;
    hit = 1'b0;
    if (b == 8'h0a || b == 8'h0d) begin
      push_key(KS_RETURN, 1'b0, 1'b0);
    end else if (b == 8'h09) begin
      push_key(KS_TAB, 1'b0, 1'b0);
    end else if (b == 8'h08 || b == CH_DEL) begin
      push_key(KS_BACKSPACE, 1'b0, 1'b0);
    end else if (b >= 8'h01 && b <= 8'h1a) begin
      push_key({8'h00, 8'h60 + b}, 1'b0, 1'b1);
    end else if (b >= 8'h41 && b <= 8'h5a) begin
      push_key({8'h00, b + 8'h20}, 1'b1, 1'b0);
    end else begin
      for (int i = 0; i < shifted_set.len(); i++) begin
        if (!hit && shifted_set[i] == b) begin
          push_key({8'h00, base_set[i]}, 1'b1, 1'b0);
          hit = 1'b1;
        end
      end
      if (!hit && b >= CH_SPACE && b <= CH_TILDE) push_key({8'h00, b}, 1'b0, 1'b0);
    end
  endfunction

  function void fresh_taps(logic [7:0] b);
    if (b == CH_ESC) pend = P_ESC;
    else plain_taps(b);
  endfunction

  // pending prefix comes out as Escape then its literal bytes
  function void flush_taps(prefix_e p);
    if (p == P_NONE) return;
    push_key(KS_ESCAPE, 1'b0, 1'b0);
    if (p == P_BRKT || p == P_THREE) plain_taps(CH_LBRACKET);
    if (p == P_THREE) plain_taps(CH_THREE);
  endfunction

  function void note_byte(logic [7:0] b, logic eor);
    prefix_e     was;
    logic [15:0] nav;
    run.delete();
    was  = pend;
    pend = P_NONE;
    nav  = '0;
    case (was)
      P_ESC: begin
        if (b == CH_LBRACKET) pend = P_BRKT;
        else begin
          flush_taps(P_ESC);
          fresh_taps(b);
        end
      end
      P_BRKT: begin
        case (b)
          CH_UP:    nav = KS_UP;
          CH_DOWN:  nav = KS_DOWN;
          CH_RIGHT: nav = KS_RIGHT;
          CH_LEFT:  nav = KS_LEFT;
          CH_HOME:  nav = KS_HOME;
          CH_END:   nav = KS_END;
          default:  nav = '0;
        endcase
        if (nav != '0) push_key(nav, 1'b0, 1'b0);
        else if (b == CH_THREE) pend = P_THREE;
        else begin
          flush_taps(P_BRKT);
          fresh_taps(b);
        end
      end
      P_THREE: begin
        if (b == CH_TILDE) push_key(KS_DELETE, 1'b0, 1'b0);
        else begin
          flush_taps(P_THREE);
          fresh_taps(b);
        end
      end
      default: fresh_taps(b);
    endcase
    if (eor) begin
      flush_taps(pend);
      pend = P_NONE;
    end
    if (run.size() > 0) run[run.size() - 1].last = 1'b1;
    foreach (run[k]) due.push_back(run[k]);
  endfunction

  function void check_tap(logic [15:0] sym, logic sh, logic ct, logic last);
    key_tap_t want;
    if (due.size() == 0) begin
      errors++;
      $display("%0t: unexpected tap sym=%h shift=%b ctrl=%b last=%b",
               $time, sym, sh, ct, last);
      return;
    end
    want = due.pop_front();
    checked++;
    if (want.sym !== sym || want.shift !== sh || want.ctrl !== ct || want.last !== last) begin
      errors++;
      $display("%0t: tap mismatch: expected sym=%h shift=%b ctrl=%b last=%b",
               $time, want.sym, want.shift, want.ctrl, want.last);
      $display("%0t: tap mismatch: got      sym=%h shift=%b ctrl=%b last=%b",
               $time, sym, sh, ct, last);
    end
  endfunction
endclass

module tb_top;

  localparam int ClkPeriod  = 10;
  localparam int HoldCycles = 150;
  localparam int WdogLimit  = 3000;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  data_byte_i;
  logic        end_of_record_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [15:0] key_symbol_o;
  logic        with_shift_o;
  logic        with_control_o;
  logic        last_of_run_o;

  tap_scoreboard sb = new;
  int            send_idle_pct = 14;
  int            recv_idle_pct = 74;
  int            bytes_sent = 0;
  int            quiet_cycles = 0;
  bit            hold_request = 1'b0;

  logic [7:0] nav_chars[6] = '{CH_UP, CH_DOWN, CH_RIGHT, CH_LEFT, CH_HOME, CH_END};
  logic [7:0] dir_bytes[22] = '{8'h00, 8'hff, 8'h0a, 8'h09, 8'h08, CH_DEL, 8'h01, 8'h1a,
                                8'h1f, 8'h5a, CH_TILDE,
                                CH_ESC, CH_LBRACKET, CH_UP,
                                CH_ESC, CH_LBRACKET, CH_THREE, CH_TILDE,
                                CH_ESC, CH_LBRACKET, CH_THREE, CH_ESC};
  logic       dir_eor[22]   = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1,
                                1'b0, 1'b1, 1'b1,
                                1'b0, 1'b0, 1'b1,
                                1'b0, 1'b0, 1'b0, 1'b1,
                                1'b0, 1'b0, 1'b0, 1'b1};

  terminal_bytes_to_key_taps u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .data_byte_i     (data_byte_i),
    .end_of_record_i (end_of_record_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .key_symbol_o    (key_symbol_o),
    .with_shift_o    (with_shift_o),
    .with_control_o  (with_control_o),
    .last_of_run_o   (last_of_run_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  task automatic send_byte(input logic [7:0] b, input logic eor);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    data_byte_i     <= b;
    end_of_record_i <= eor;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_byte(b, eor);
    bytes_sent++;
  endtask

  // a random byte, a complete escape sequence, or a cut-short prefix with an optional follow-up byte
  task automatic send_random_group();
    logic [7:0] seq[$];
    logic       tail_eor;
    int         pick;
    int         cut;
    pick     = $urandom_range(99);
    tail_eor = ($urandom_range(99) < 80);
    if (pick < 35) begin
      seq.push_back(8'($urandom_range(255)));
      tail_eor = 1'($urandom_range(1));
    end else if (pick < 62) begin
      seq = {CH_ESC, CH_LBRACKET, nav_chars[$urandom_range(5)]};
    end else if (pick < 78) begin
      seq = {CH_ESC, CH_LBRACKET, CH_THREE, CH_TILDE};
    end else begin
      seq = {CH_ESC, CH_LBRACKET, CH_THREE};
      cut = $urandom_range(1, 3);
      while (seq.size() > cut) void'(seq.pop_back());
      case ($urandom_range(3))
        0: seq.push_back(8'($urandom_range(255)));
        1: seq.push_back(CH_ESC);
        2: seq.push_back(8'($urandom_range(8'h20, 8'h7e)));
        default: ;
      endcase
      tail_eor = 1'($urandom_range(1));
    end
    foreach (seq[k]) send_byte(seq[k], (k == seq.size() - 1) ? tail_eor : 1'b0);
  endtask

  // receiver side: random stalls, or one long hold-off on request
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_tap(key_symbol_o, with_shift_o, with_control_o, last_of_run_o);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WdogLimit) begin
        $display("%0t: no transfer for %0d cycles, %0d taps outstanding",
                 $time, quiet_cycles, sb.due.size());
        $display("tb_top: FAIL");
        $finish;
      end
    end
  end

  initial begin
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    data_byte_i     = 8'h00;
    end_of_record_i = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_bytes[k]) send_byte(dir_bytes[k], dir_eor[k]);
    while (bytes_sent < 140) send_random_group();

    send_idle_pct = 74;
    recv_idle_pct = 14;
    while (bytes_sent < 280) send_random_group();

    // no idling; long receiver hold so the input backs up
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request  = 1'b1;
    while (bytes_sent < 420) send_random_group();

    in_valid_i <= 1'b0;
    while (sb.due.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("tb_top: %0d bytes sent, %0d taps checked, %0d errors", bytes_sent, sb.checked,
             sb.errors);
    $display("tb_top: covered key map edges, arrows, home, end, delete, broken prefixes");
    if (sb.errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
